>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is held off while reset is high.
`define SLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("shell line tokenizer check failed");

// Check that also holds through reset.
`define SLT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("shell line tokenizer reset check failed");

`endif

>>> design/slt_pkg.sv
`timescale 1ns / 1ps

package slt_pkg;

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_ARG,
    MODE_SKIP,
    MODE_NAME
  } mode_t;

  localparam logic [1:0] KIND_ARG = 2'd0;
  localparam logic [1:0] KIND_IN  = 2'd1;
  localparam logic [1:0] KIND_OUT = 2'd2;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic blank;
    logic space;
    logic redir;
    logic gt;
    logic bslash;
    logic dquote;
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_out;
    logic [1:0] token_kind;
    logic       token_end;
    logic       token_empty;
    logic       line_end;
    logic [5:0] arg_total;
    logic       in_redirect_seen;
    logic       out_redirect_seen;
    logic       overflow_flag;
  } result_t;

endpackage

>>> design/slt_front.sv
`timescale 1ns / 1ps

module slt_front import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] char_in,
  input  logic       line_last,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_ready
);

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.blank  = (c == CH_SPACE) || (c == CH_TAB);
    r.space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    r.redir  = (c == CH_LT) || (c == CH_GT);
    r.gt     = (c == CH_GT);
    r.bslash = (c == CH_BSLASH);
    r.dquote = (c == CH_DQUOTE);
    return r;
  endfunction

  assign s_tready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_tready) begin
      q_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q_item.ch   <= char_in;
      q_item.last <= line_last;
      q_item.cls  <= classify(char_in);
    end
  end

endmodule

>>> design/slt_queue.sv
`timescale 1ns / 1ps

module slt_queue import slt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam logic [1:0] DEPTH = 2'd2;

  item_t      slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign in_ready  = (count != DEPTH);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

>>> design/slt_back.sv
`timescale 1ns / 1ps

module slt_back import slt_pkg::*; #(
  parameter int MAX_ARGS      = 63,
  parameter int MAX_TOKEN_LEN = 1023
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t res
);

  localparam int ACNT_W = $clog2(MAX_ARGS + 1);
  localparam int TLEN_W = $clog2(MAX_TOKEN_LEN + 1);

  typedef struct packed {
    mode_t             mode;
    logic              quote;
    logic              esc;
    logic              rio;
    logic [TLEN_W-1:0] tlen;
    logic [ACNT_W-1:0] acnt;
    logic [1:0]        rflags;
    logic              ovf;
    logic              drop;
  } st_t;

  typedef struct packed {
    logic       chr;
    logic [7:0] ch;
    logic [1:0] ckind;
    logic       fin;
    logic [1:0] kind;
    logic       empty;
  } ev_t;

  typedef struct packed {
    st_t s;
    ev_t e;
  } wk_t;

  localparam st_t ST_RESET = '{mode: MODE_BETWEEN, default: '0};

  function automatic wk_t take(input wk_t w, input logic [7:0] c, input logic [1:0] k);
    wk_t r;
    r = w;
    if (r.s.tlen >= TLEN_W'(MAX_TOKEN_LEN)) begin
      r.s.ovf = 1'b1;
    end else begin
      r.s.tlen  = r.s.tlen + TLEN_W'(1);
      r.e.chr   = 1'b1;
      r.e.ch    = c;
      r.e.ckind = k;
    end
    return r;
  endfunction

  function automatic wk_t lit_arg(input wk_t w, input logic [7:0] c);
    wk_t r;
    r = w;
    // first byte of an argument once the count is full: drop the whole argument
    if ((r.s.tlen == '0) && !r.s.drop && (r.s.acnt >= ACNT_W'(MAX_ARGS))) begin
      r.s.drop = 1'b1;
      r.s.ovf  = 1'b1;
    end
    if (!r.s.drop) r = take(r, c, KIND_ARG);
    return r;
  endfunction

  st_t     st;
  st_t     st_next;
  wk_t     w;
  logic    emit;
  logic    pop;
  result_t res_next;

  assign in_ready = !m_valid || m_ready;
  assign pop      = in_valid && in_ready;

  always_comb begin
    logic       do_name;
    logic       do_arg;
    logic       do_betw;
    logic [1:0] nkind;
    logic [1:0] lkind;
    logic [7:0] c;
    cls_t       cl;
    c       = in_item.ch;
    cl      = in_item.cls;
    w.s     = st;
    w.e     = '0;
    do_name = 1'b0;
    do_arg  = 1'b0;
    do_betw = 1'b0;
    unique case (st.mode)
      MODE_ARG:     do_arg = 1'b1;
      MODE_SKIP: begin
        if (!cl.blank) begin
          w.s.mode = MODE_NAME;
          do_name  = 1'b1;
        end
      end
      MODE_NAME:    do_name = 1'b1;
      MODE_BETWEEN: do_betw = 1'b1;
    endcase

    nkind = w.s.rio ? KIND_OUT : KIND_IN;

    if (do_name) begin
      if (w.s.esc) begin
        w.s.esc = 1'b0;
        w = take(w, c, nkind);
      end else if (w.s.quote || (!cl.space && !cl.redir)) begin
        if (cl.bslash) begin
          w.s.esc = 1'b1;
        end else if (cl.dquote) begin
          w.s.quote = !w.s.quote;
        end else begin
          w = take(w, c, nkind);
        end
      end else begin
        w.e.fin    = 1'b1;
        w.e.kind   = nkind;
        w.e.empty  = (w.s.tlen == '0);
        w.s.rflags = w.s.rflags | nkind;
        w.s.mode   = MODE_BETWEEN;
        w.s.tlen   = '0;
        do_betw    = 1'b1;
      end
    end

    if (do_arg) begin
      if (w.s.esc) begin
        w.s.esc = 1'b0;
        w = lit_arg(w, c);
      end else if (cl.bslash) begin
        w.s.esc = 1'b1;
      end else if (cl.dquote) begin
        w.s.quote = !w.s.quote;
      end else if (!w.s.quote && (cl.blank || cl.redir)) begin
        if ((w.s.tlen != '0) && !w.s.drop) begin
          w.e.fin   = 1'b1;
          w.e.kind  = KIND_ARG;
          w.e.empty = 1'b0;
          w.s.acnt  = w.s.acnt + ACNT_W'(1);
        end
        w.s.mode = MODE_BETWEEN;
        w.s.tlen = '0;
        w.s.drop = 1'b0;
        do_betw  = 1'b1;
      end else begin
        w = lit_arg(w, c);
      end
    end

    if (do_betw && !cl.blank) begin
      w.s.tlen = '0;
      if (cl.redir) begin
        w.s.mode = MODE_SKIP;
        w.s.rio  = cl.gt;
      end else begin
        // escape is always clear between tokens
        w.s.mode = MODE_ARG;
        w.s.drop = 1'b0;
        if (cl.bslash) begin
          w.s.esc = 1'b1;
        end else if (cl.dquote) begin
          w.s.quote = !w.s.quote;
        end else begin
          w = lit_arg(w, c);
        end
      end
    end

    lkind = w.s.rio ? KIND_OUT : KIND_IN;
    if (in_item.last) begin
      if (w.s.mode == MODE_ARG) begin
        if ((w.s.tlen != '0) && !w.s.drop) begin
          w.s.acnt = w.s.acnt + ACNT_W'(1);
          if (!w.e.fin) begin
            w.e.fin   = 1'b1;
            w.e.kind  = KIND_ARG;
            w.e.empty = 1'b0;
          end
        end
      end else if ((w.s.mode == MODE_SKIP) || (w.s.mode == MODE_NAME)) begin
        w.s.rflags = w.s.rflags | lkind;
        if (!w.e.fin) begin
          w.e.fin   = 1'b1;
          w.e.kind  = lkind;
          w.e.empty = (w.s.tlen == '0);
        end
      end
    end

    emit    = w.e.fin || w.e.chr || in_item.last;
    st_next = in_item.last ? ST_RESET : w.s;
  end

  always_comb begin
    res_next.has_char          = w.e.chr;
    res_next.char_out          = w.e.chr ? w.e.ch : 8'd0;
    res_next.token_kind        = w.e.fin ? w.e.kind : (w.e.chr ? w.e.ckind : KIND_ARG);
    res_next.token_end         = w.e.fin;
    res_next.token_empty       = w.e.fin && w.e.empty;
    res_next.line_end          = in_item.last;
    res_next.arg_total         = (32'(w.s.acnt) > 32'd63) ? 6'd63 : 6'(w.s.acnt);
    res_next.in_redirect_seen  = w.s.rflags[0];
    res_next.out_redirect_seen = w.s.rflags[1];
    res_next.overflow_flag     = w.s.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_RESET;
      m_valid <= 1'b0;
    end else if (pop) begin
      st      <= st_next;
      m_valid <= emit;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) res <= res_next;
  end

endmodule

>>> design/shell_line_tokenizer_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Dir  Data                                         Last      User
// s_*      in   char_in[7:0]                                 line_last -
// m_*      out  has_char, char_out, token_end, token_empty,  line_end  token_kind
//               arg_total, in/out_redirect_seen, overflow
//
// One byte per cycle sustained while m_tready is high; a taken request passes
// through the classify register, the two-entry queue and the result register.
// The back-end state machine handles a byte per cycle in one step unless stalled.
// Synchronous reset empties the pipeline and returns the scanner to between tokens.
// A stall on m_* fills the result register, then the queue, then the classify
// register, and only then drops s_tready.
module shell_line_tokenizer_unit import slt_pkg::*; #(
  parameter int MAX_ARGS      = 63,
  parameter int MAX_TOKEN_LEN = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // has_char[0], char_out[8:1], token_end[9], token_empty[10], arg_total[16:11],
  // in_redirect_seen[17], out_redirect_seen[18], overflow_flag[19], zero[23:20]
  output logic [23:0] m_tdata,
  output logic [1:0]  m_tuser,   // token_kind[1:0]
  output logic        m_tlast
);

  logic    f_valid;
  logic    f_ready;
  item_t   f_item;
  logic    b_valid;
  logic    b_ready;
  item_t   b_item;
  result_t res;

  slt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .char_in   (s_tdata),
    .line_last (s_tlast),
    .q_valid   (f_valid),
    .q_item    (f_item),
    .q_ready   (f_ready)
  );

  slt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  slt_back #(
    .MAX_ARGS      (MAX_ARGS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_item  (b_item),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .res      (res)
  );

  assign m_tdata = {4'b0000, res.overflow_flag, res.out_redirect_seen, res.in_redirect_seen,
                    res.arg_total, res.token_empty, res.token_end, res.char_out,
                    res.has_char};
  assign m_tuser = res.token_kind;
  assign m_tlast = res.line_end;

  `SLT_ASSERT_RST(a_rst_no_result, rst |=> !m_tvalid)
  `SLT_ASSERT(a_empty_is_redirect, m_tvalid && res.token_empty |-> res.token_end && (res.token_kind != KIND_ARG))
  `SLT_ASSERT(a_char_zero_when_none, m_tvalid && !res.has_char |-> (res.char_out == 8'd0))
  `SLT_ASSERT(a_count_grows_in_line, m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (res.arg_total >= $past(res.arg_total)))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slt_pkg::*;

  localparam int MAX_ARGS      = 63;
  localparam int MAX_TOKEN_LEN = 1023;
  localparam int MAX_IDLE      = 17;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    int unsigned gap;
    bit          hold;
  } line_byte_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  shell_line_tokenizer_unit #(
    .MAX_ARGS      (MAX_ARGS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_byte_t  line_bytes[$];
  logic [7:0]  line_q[$];
  result_t     token_results_due[$];
  int unsigned bytes_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;

  // Scanner state of the predictor.
  mode_t       scan_st    = MODE_BETWEEN;
  bit          quote_on   = 1'b0;
  bit          esc_on     = 1'b0;
  bit          redir_out  = 1'b0;
  int unsigned tok_len    = 0;
  int unsigned arg_cnt    = 0;
  bit [1:0]    redir_seen = 2'b00;
  bit          ovf        = 1'b0;
  bit          arg_drop   = 1'b0;

  // What the current byte produced.
  bit          out_has;
  logic [7:0]  out_byte;
  logic [1:0]  out_byte_kind;
  bit          out_end;
  logic [1:0]  out_end_kind;
  bit          out_empty;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_redir(logic [7:0] c);
    return c == CH_LT || c == CH_GT;
  endfunction

  function automatic logic [1:0] name_kind();
    return redir_out ? KIND_OUT : KIND_IN;
  endfunction

  function automatic void reset_scanner();
    scan_st    = MODE_BETWEEN;
    quote_on   = 1'b0;
    esc_on     = 1'b0;
    redir_out  = 1'b0;
    tok_len    = 0;
    arg_cnt    = 0;
    redir_seen = 2'b00;
    ovf        = 1'b0;
    arg_drop   = 1'b0;
  endfunction

  function automatic void keep_byte(logic [7:0] c, logic [1:0] kind);
    if (tok_len >= MAX_TOKEN_LEN) begin
      ovf = 1'b1;
    end else begin
      tok_len++;
      out_has       = 1'b1;
      out_byte      = c;
      out_byte_kind = kind;
    end
  endfunction

  function automatic void arg_literal(logic [7:0] c);
    // drop the whole argument once the count is full
    if (tok_len == 0 && !arg_drop && arg_cnt >= MAX_ARGS) begin
      arg_drop = 1'b1;
      ovf      = 1'b1;
    end
    if (!arg_drop) keep_byte(c, KIND_ARG);
  endfunction

  function automatic void arg_plain(logic [7:0] c);
    if (c == CH_BSLASH) esc_on = 1'b1;
    else if (c == CH_DQUOTE) quote_on = ~quote_on;
    else arg_literal(c);
  endfunction

  function automatic void start_token(logic [7:0] c);
    if (!is_blank(c)) begin
      tok_len = 0;
      if (is_redir(c)) begin
        scan_st   = MODE_SKIP;
        redir_out = (c == CH_GT);
      end else begin
        scan_st  = MODE_ARG;
        arg_drop = 1'b0;
        arg_plain(c);
      end
    end
  endfunction

  function automatic void close_arg();
    if (tok_len > 0 && !arg_drop) begin
      out_end      = 1'b1;
      out_end_kind = KIND_ARG;
      out_empty    = 1'b0;
      arg_cnt++;
    end
    scan_st  = MODE_BETWEEN;
    tok_len  = 0;
    arg_drop = 1'b0;
  endfunction

  function automatic void arg_byte(logic [7:0] c);
    if (esc_on) begin
      esc_on = 1'b0;
      arg_literal(c);
    end else if (!quote_on && (is_blank(c) || is_redir(c))) begin
      close_arg();
      start_token(c);
    end else begin
      arg_plain(c);
    end
  endfunction

  function automatic void close_name();
    out_end      = 1'b1;
    out_end_kind = name_kind();
    out_empty    = (tok_len == 0);
    redir_seen   = redir_seen | (redir_out ? 2'b10 : 2'b01);
    scan_st      = MODE_BETWEEN;
    tok_len      = 0;
  endfunction

  function automatic void name_byte(logic [7:0] c);
    if (esc_on) begin
      esc_on = 1'b0;
      keep_byte(c, name_kind());
    end else if (quote_on || (!is_space(c) && !is_redir(c))) begin
      if (c == CH_BSLASH) esc_on = 1'b1;
      else if (c == CH_DQUOTE) quote_on = ~quote_on;
      else keep_byte(c, name_kind());
    end else begin
      close_name();
      start_token(c);
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic last);
    result_t r;
    out_has = 1'b0; out_byte = 8'h00; out_byte_kind = KIND_ARG;
    out_end = 1'b0; out_end_kind = KIND_ARG; out_empty = 1'b0;
    case (scan_st)
      MODE_ARG: arg_byte(c);
      MODE_SKIP: begin
        if (!is_blank(c)) begin
          scan_st = MODE_NAME;
          name_byte(c);
        end
      end
      MODE_NAME: name_byte(c);
      default: start_token(c);
    endcase
    // line end closes whatever is open; only the first end is reported
    if (last) begin
      if (scan_st == MODE_ARG) begin
        if (tok_len > 0 && !arg_drop) begin
          arg_cnt++;
          if (!out_end) begin
            out_end      = 1'b1;
            out_end_kind = KIND_ARG;
            out_empty    = 1'b0;
          end
        end
      end else if (scan_st == MODE_SKIP || scan_st == MODE_NAME) begin
        redir_seen = redir_seen | (redir_out ? 2'b10 : 2'b01);
        if (!out_end) begin
          out_end      = 1'b1;
          out_end_kind = name_kind();
          out_empty    = (tok_len == 0);
        end
      end
    end
    if (out_has || out_end || last) begin
      r.has_char          = out_has;
      r.char_out          = out_has ? out_byte : 8'h00;
      r.token_kind        = out_end ? out_end_kind : (out_has ? out_byte_kind : KIND_ARG);
      r.token_end         = out_end;
      r.token_empty       = out_end ? out_empty : 1'b0;
      r.line_end          = last;
      r.arg_total         = (arg_cnt > 63) ? 6'd63 : 6'(arg_cnt);
      r.in_redirect_seen  = redir_seen[0];
      r.out_redirect_seen = redir_seen[1];
      r.overflow_flag     = ovf;
      token_results_due.push_back(r);
    end
    if (last) reset_scanner();
  endfunction

  // Driver: present queued bytes after their drawn idle gaps.
  always @(posedge clk) begin : drive_bytes
    line_byte_t  nxt;
    int unsigned wait_cnt;
    if (rst) begin
      s_tvalid <= 1'b0;
      wait_cnt = 0;
      reset_scanner();
    end else begin
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (line_bytes.size() > 0 && wait_cnt >= line_bytes[0].gap &&
            !(line_bytes[0].hold && token_results_due.size() > 0)) begin
          nxt = line_bytes.pop_front();
          s_tdata  <= nxt.ch;
          s_tlast  <= nxt.last;
          s_tvalid <= 1'b1;
          wait_cnt = 0;
        end else begin
          s_tvalid <= 1'b0;
          if (line_bytes.size() > 0 && wait_cnt < line_bytes[0].gap) wait_cnt++;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: check each result, then hold off ready for a drawn stall.
  always @(posedge clk) begin : watch_results
    result_t     want;
    int unsigned stall_cnt;
    if (rst) begin
      m_tready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (token_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          want = token_results_due.pop_front();
          cmp_field("has_char", want.has_char, m_tdata[0]);
          cmp_field("char_out", want.char_out, m_tdata[8:1]);
          cmp_field("token_kind", want.token_kind, m_tuser);
          cmp_field("token_end", want.token_end, m_tdata[9]);
          cmp_field("token_empty", want.token_empty, m_tdata[10]);
          cmp_field("line_end", want.line_end, m_tlast);
          cmp_field("arg_total", want.arg_total, m_tdata[16:11]);
          cmp_field("in_redirect_seen", want.in_redirect_seen, m_tdata[17]);
          cmp_field("out_redirect_seen", want.out_redirect_seen, m_tdata[18]);
          cmp_field("overflow_flag", want.overflow_flag, m_tdata[19]);
        end
        results_seen++;
        // every few dozen results run a stretch with no stalls
        stall_cnt = (results_seen % 96 < 24) ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic commit_line(input bit fast, input bit hold);
    line_byte_t b;
    foreach (line_q[i]) begin
      b.ch   = line_q[i];
      b.last = (i == line_q.size() - 1);
      b.gap  = fast ? 0 : $urandom_range(0, MAX_IDLE);
      b.hold = hold && (i == 0);
      line_bytes.push_back(b);
    end
    line_q.delete();
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0: return CH_DQUOTE;
      1: return CH_BSLASH;
      2: return CH_LT;
      3: return CH_GT;
      4: return CH_SPACE;
      5: return CH_TAB;
      6: return CH_LF + 8'($urandom_range(0, 3));
      7: return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic add_word(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          line_q.push_back(CH_BSLASH);
          line_q.push_back(8'($urandom_range(0, 255)));
        end
        1: line_q.push_back(8'($urandom_range(0, 255)));
        2: line_q.push_back(CH_DQUOTE);
        default: line_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned random_count;
    int unsigned line_no;
    int unsigned ntok;
    random_count = 0;
    line_no = 0;

    // quoted blank, escaped '<', name ended by LF that starts an argument,
    // NUL byte, argument and output redirect both ending on the final byte
    line_q = '{8'h78, CH_DQUOTE, CH_SPACE, CH_DQUOTE, CH_BSLASH, CH_LT, CH_SPACE,
               CH_LT, 8'h66, CH_LF, CH_NUL, CH_GT};
    commit_line(1'b0, 1'b0);
    // empty argument, empty output name cut by '<', quote left open,
    // trailing backslash
    line_q = '{CH_DQUOTE, CH_DQUOTE, CH_SPACE, CH_GT, CH_LT, 8'hFF, CH_DQUOTE,
               CH_CR, CH_BSLASH};
    commit_line(1'b0, 1'b0);
    line_q = '{CH_TAB, 8'h80, 8'h0C, 8'h01};
    commit_line(1'b1, 1'b0);
    line_q = '{CH_SPACE};
    commit_line(1'b0, 1'b0);
    random_count = line_bytes.size();

    while (random_count < 850) begin
      line_no++;
      if (line_no == 3) begin
        // more arguments than the count allows
        for (int k = 0; k < MAX_ARGS + 8; k++) begin
          line_q.push_back(8'h41 + 8'(k % 26));
          line_q.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
        end
      end else if (line_no == 6) begin
        // argument longer than the length limit, then a short output name
        for (int k = 0; k < MAX_TOKEN_LEN + 7; k++)
          line_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
        line_q.push_back(CH_SPACE);
        line_q.push_back(CH_GT);
        line_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          // noise line
          repeat ($urandom_range(1, 12)) line_q.push_back(pick_char());
        end else begin
          ntok = $urandom_range(1, 7);
          for (int unsigned t = 0; t < ntok; t++) begin
            if (t > 0 || $urandom_range(0, 3) == 0)
              repeat ($urandom_range(0, 2))
                line_q.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
            case ($urandom_range(0, 5))
              0, 1: begin
                line_q.push_back(($urandom_range(0, 1) != 0) ? CH_LT : CH_GT);
                if ($urandom_range(0, 1) != 0) line_q.push_back(CH_SPACE);
                add_word($urandom_range(0, 5));
              end
              2: begin
                line_q.push_back(CH_DQUOTE);
                add_word($urandom_range(0, 4));
                line_q.push_back(pick_char());
                add_word($urandom_range(0, 4));
                line_q.push_back(CH_DQUOTE);
              end
              default: add_word($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 7) == 0) line_q.push_back(CH_LF + 8'($urandom_range(0, 3)));
          end
          if ($urandom_range(0, 3) == 0) line_q.push_back(CH_SPACE);
        end
      end
      random_count += line_q.size();
      // now and then pause the sender until all results are in
      commit_line($urandom_range(0, 4) == 0, (line_no % 4) == 0);
    end
    bytes_total = line_bytes.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total) @(negedge clk);
    while (token_results_due.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("shell_line_tokenizer_unit verification clean");
    end else begin
      $display("shell_line_tokenizer_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("shell_line_tokenizer_unit verification failed");
    $finish;
  end

endmodule
